FILE: src/atrp_pkg.sv
// Shared types, constants and word tables for the AT response parser.
package atrp_pkg;

    localparam int INDEX_BITS = 16;
    localparam int LEN_BITS   = 16;
    localparam int ADDR_BITS  = 3;

    localparam logic [7:0] END_BYTE   = 8'd255;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_O       = 8'h4F;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_N       = 8'h4E;
    localparam logic [7:0] CH_E       = 8'h45;
    localparam logic [LEN_BITS-1:0] LEN_TEN = LEN_BITS'(10);

    localparam logic [ADDR_BITS-3:0] REG_ACCEPT_ACK = '0;

    typedef enum logic [1:0] {
        W_NONE   = 2'd0,
        W_OK     = 2'd1,
        W_ALR    = 2'd2,
        W_CONNEC = 2'd3
    } t_word;

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_HEADER = 2'd1,
        DEC_ACK    = 2'd2
    } t_decision;

    typedef struct packed {
        logic                success;
        logic [LEN_BITS-1:0] data_length;
        logic [LEN_BITS-1:0] data_start;
        logic                got_header;
    } t_result;

    function automatic logic [2:0] word_len(input t_word w);
        case (w)
            W_OK:     word_len = 3'd2;
            W_ALR:    word_len = 3'd3;
            W_CONNEC: word_len = 3'd6;
            default:  word_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(input t_word w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'd0;
        case (w)
            W_OK: begin
                case (p)
                    3'd0:    c = CH_O;
                    3'd1:    c = CH_K;
                    default: c = 8'd0;
                endcase
            end
            W_ALR: begin
                case (p)
                    3'd0:    c = CH_A;
                    3'd1:    c = CH_L;
                    3'd2:    c = CH_R;
                    default: c = 8'd0;
                endcase
            end
            W_CONNEC: begin
                case (p)
                    3'd0:    c = CH_C;
                    3'd1:    c = CH_O;
                    3'd2:    c = CH_N;
                    3'd3:    c = CH_N;
                    3'd4:    c = CH_E;
                    3'd5:    c = CH_C;
                    default: c = 8'd0;
                endcase
            end
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic t_word word_start(input logic [7:0] b);
        t_word w;
        w = W_NONE;
        if (b == CH_O) w = W_OK;
        else if (b == CH_A) w = W_ALR;
        else if (b == CH_C) w = W_CONNEC;
        return w;
    endfunction

endpackage

FILE: src/atrp_byte_if.sv
// Handshake channel carrying one received byte per word.
interface atrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: src/atrp_res_if.sv
// Handshake channel carrying one parse result per word.
interface atrp_res_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [15:0] data_length;
    logic [15:0] data_start;
    logic        got_header;

    modport source (output valid, output success, output data_length,
                    output data_start, output got_header, input ready);
    modport sink (input valid, input success, input data_length,
                  input data_start, input got_header, output ready);
endinterface

FILE: src/atrp_apb_regs.sv
// APB configuration register bank of the AT response parser.
module atrp_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [atrp_pkg::ADDR_BITS-1:0] i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready,
    output logic                          o_accept_ack
);
    import atrp_pkg::*;

    logic r_accept_ack;
    logic n_accept_ack;
    logic hit;

    assign hit      = (i_paddr[ADDR_BITS-1:2] == REG_ACCEPT_ACK);
    assign o_pready = 1'b1;

    always_comb begin
        n_accept_ack = r_accept_ack;
        if (i_psel && i_penable && i_pwrite && hit) begin
            n_accept_ack = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_ack <= 1'b0;
        end else begin
            r_accept_ack <= n_accept_ack;
        end
    end

    assign o_prdata     = hit ? {31'd0, r_accept_ack} : 32'd0;
    assign o_accept_ack = r_accept_ack;

endmodule

FILE: src/atrp_parse.sv
// Byte input register, message parse state and result register.
module atrp_parse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept_ack,
    atrp_byte_if.sink   i_rx,
    atrp_res_if.source  o_res
);
    import atrp_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_byte;
    logic [INDEX_BITS-1:0] r_pos;
    logic [2:0]            r_prog;
    t_word                 r_word;
    logic                  r_in_len;
    logic [LEN_BITS-1:0]   r_len;
    logic [LEN_BITS-1:0]   r_start;
    t_decision             r_decided;
    logic                  r_out_valid;
    t_result               r_res;

    logic [INDEX_BITS-1:0] n_pos;
    logic [2:0]            n_prog;
    t_word                 n_word;
    logic                  n_in_len;
    logic [LEN_BITS-1:0]   n_len;
    logic [LEN_BITS-1:0]   n_start;
    t_decision             n_decided;
    t_result               n_res;

    logic                  is_end;
    logic                  advance;
    logic                  in_ready;
    logic [INDEX_BITS-1:0] pos_inc;

    assign is_end   = (r_byte == END_BYTE);
    assign advance  = r_in_valid && (!is_end || !r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;
    assign pos_inc  = r_pos + 1'b1;

    always_comb begin
        n_pos     = r_pos;
        n_prog    = r_prog;
        n_word    = r_word;
        n_in_len  = r_in_len;
        n_len     = r_len;
        n_start   = r_start;
        n_decided = r_decided;
        n_res     = r_res;
        if (is_end) begin
            n_res.success     = (r_decided != DEC_NONE);
            n_res.got_header  = (r_decided == DEC_HEADER);
            n_res.data_length = (r_decided == DEC_HEADER) ? r_len : '0;
            n_res.data_start  = (r_decided == DEC_HEADER) ? r_start : '0;
            n_pos     = '0;
            n_prog    = 3'd0;
            n_word    = W_NONE;
            n_in_len  = 1'b0;
            n_len     = '0;
            n_start   = '0;
            n_decided = DEC_NONE;
        end else begin
            n_pos = pos_inc;
            if (r_decided == DEC_NONE) begin
                if (r_in_len) begin
                    if (r_byte == CH_COLON) begin
                        n_start   = LEN_BITS'(pos_inc);
                        n_in_len  = 1'b0;
                        n_decided = DEC_HEADER;
                    end else begin
                        n_len = r_len * LEN_TEN + {{(LEN_BITS-8){1'b0}}, r_byte}
                                - {{(LEN_BITS-8){1'b0}}, CH_ZERO};
                    end
                end else if (r_byte == CH_COMMA) begin
                    n_in_len = 1'b1;
                    n_len    = '0;
                    n_word   = W_NONE;
                    n_prog   = 3'd0;
                end else begin
                    if (r_word != W_NONE && r_prog < word_len(r_word)
                        && r_byte == word_char(r_word, r_prog)) begin
                        n_prog = r_prog + 3'd1;
                    end else if (r_word == W_CONNEC && r_prog == 3'd2
                                 && r_byte == CH_K) begin
                        n_word = W_OK;
                        n_prog = 3'd2;
                    end else begin
                        n_word = word_start(r_byte);
                        n_prog = (n_word != W_NONE) ? 3'd1 : 3'd0;
                    end
                    if (n_word != W_NONE && n_prog == word_len(n_word)) begin
                        if (i_accept_ack) begin
                            n_decided = DEC_ACK;
                            n_word    = W_NONE;
                            n_prog    = 3'd0;
                        end else begin
                            n_word = word_start(r_byte);
                            n_prog = (n_word != W_NONE) ? 3'd1 : 3'd0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_prog      <= 3'd0;
            r_word      <= W_NONE;
            r_in_len    <= 1'b0;
            r_len       <= '0;
            r_start     <= '0;
            r_decided   <= DEC_NONE;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_pos     <= n_pos;
                r_prog    <= n_prog;
                r_word    <= n_word;
                r_in_len  <= n_in_len;
                r_len     <= n_len;
                r_start   <= n_start;
                r_decided <= n_decided;
            end
            if (advance && is_end) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
        if (advance && is_end) begin
            r_res <= n_res;
        end
    end

    assign i_rx.ready        = in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.success     = r_res.success;
    assign o_res.data_length = r_res.data_length;
    assign o_res.data_start  = r_res.data_start;
    assign o_res.got_header  = r_res.got_header;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_end |=> r_pos == '0 && r_decided == DEC_NONE && !r_in_len)
        else $error("message state not cleared after end byte");

    a_len_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_len |-> r_decided == DEC_NONE)
        else $error("length field open after a decision");

    a_prog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_word != W_NONE && r_prog < word_len(r_word))
        || (r_word == W_NONE && r_prog == 3'd0))
        else $error("match progress out of range");

    a_header_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.got_header |-> r_res.success)
        else $error("header result without success");

endmodule

FILE: src/at_response_parser_core.sv
// Top level of the AT response parser.
// Usage:
//   i_rx carries modem reply bytes, one per word; the byte 255 closes a
//   message (receive timeout). Each closed message yields exactly one word
//   on o_res: success, data_length, data_start and got_header. Other bytes
//   yield nothing. A comma opens a decimal length field ended by a colon;
//   with accept_ack set, OK, ALR or CONNEC also give success.
//   The APB port holds accept_ack at address 0; write it only while idle.
// Timing:
//   One byte is taken every cycle unless an end byte waits for o_res. A
//   byte is registered in the input register, then updates the parse
//   state; an end byte loads the result register and raises o_res.valid.
// Reset and stall:
//   Synchronous active-low reset clears the parse state, both valid flags
//   and accept_ack. While o_res is stalled, ordinary bytes keep flowing; an
//   end byte waits in the input register until the result register frees.
module at_response_parser_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    atrp_byte_if.sink                     i_rx,
    atrp_res_if.source                    o_res,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [atrp_pkg::ADDR_BITS-1:0] i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    import atrp_pkg::*;

    logic accept_ack;

    atrp_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .o_prdata     (o_prdata),
        .o_pready     (o_pready),
        .o_accept_ack (accept_ack)
    );

    atrp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept_ack (accept_ack),
        .i_rx         (i_rx),
        .o_res        (o_res)
    );

endmodule
